@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the top level of the mesh generator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CSM_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define CSM_NEVER(name, clk, rstn, expr) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define CSM_ASSERT(name, clk, rstn, prop)
`define CSM_NEVER(name, clk, rstn, expr)
`endif
`endif

@@ src/csm_pkg.sv @@
// ----------------------------------------------------------------------------
// Cube sphere mesh package
// Types and constants shared by the mesh generator modules.
// ----------------------------------------------------------------------------
package csm_pkg;

    localparam int MAX_GRID = 64;
    localparam logic [6:0] GRID_RESET = 7'd10;
    localparam logic [6:0] GRID_MIN = 7'd2;
    localparam logic [6:0] GRID_MAX = 7'(MAX_GRID);
    localparam int NSTG = 16;

    localparam logic REQ_VERTEX = 1'b0;
    localparam logic REQ_SEGMENT = 1'b1;

    localparam logic [2:0] FACE_PX = 3'd0;
    localparam logic [2:0] FACE_NX = 3'd1;
    localparam logic [2:0] FACE_PY = 3'd2;
    localparam logic [2:0] FACE_NY = 3'd3;
    localparam logic [2:0] FACE_PZ = 3'd4;
    localparam logic [2:0] FACE_NZ = 3'd5;

    typedef struct packed {
        logic       req_type;
        logic [2:0] face;
        logic [5:0] row;
        logic [5:0] col;
    } csm_req_t;

    typedef struct packed {
        logic [14:0]        vertex_index;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [14:0]        seg_start;
        logic [14:0]        seg_end;
        logic               last;
    } csm_res_t;

    typedef struct packed {
        logic             seg;
        logic [2:0]       neg;
        logic [2:0][43:0] tgt;
        logic [13:0]      s;
        logic [14:0]      vidx;
        logic [14:0]      s0;
        logic [14:0]      e0;
        logic [14:0]      s1;
        logic [14:0]      e1;
    } csm_item_t;

    typedef struct packed {
        logic [2:0][47:0] p;
        logic [2:0][31:0] q;
        logic [2:0][15:0] u;
    } csm_srch_t;

endpackage

@@ src/csm_front.sv @@
// ----------------------------------------------------------------------------
// Cube sphere mesh front end
// Checks requests, builds the cube point, its squared length and the indices.
// ----------------------------------------------------------------------------
module csm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [6:0]         grid,
    input  logic               req_valid,
    input  csm_pkg::csm_req_t  req,
    output logic               vld,
    output csm_pkg::csm_item_t itm
);

    logic [6:0] n_eff;
    logic       keep;

    logic       s1_vld_reg, s1_vld_next;
    logic       s1_seg_reg;
    logic [2:0] s1_f_reg;
    logic [5:0] s1_i_reg, s1_j_reg;
    logic [6:0] s1_n_reg;

    logic              s2_vld_reg;
    logic              s2_seg_reg, s2_lc_reg;
    logic [2:0]        s2_f_reg;
    logic [5:0]        s2_i_reg, s2_j_reg;
    logic [6:0]        s2_n_reg;
    logic signed [7:0] s2_d_reg, s2_a_reg, s2_b_reg;
    logic [12:0]       s2_ri_reg, s2_rn_reg, s2_rl_reg, s2_nn_reg;
    logic signed [7:0] s2_d_next, s2_a_next, s2_b_next;

    logic              s3_vld_reg;
    logic              s3_seg_reg, s3_lc_reg;
    logic [5:0]        s3_i_reg, s3_j_reg;
    logic [6:0]        s3_n_reg;
    logic [12:0]       s3_ri_reg, s3_rn_reg, s3_rl_reg;
    logic [2:0]        s3_neg_reg;
    logic [2:0][11:0]  s3_msq_reg;
    logic [13:0]       s3_s_reg;
    logic [14:0]       s3_fb_reg;
    logic signed [7:0] v0, v1, v2;
    logic [2:0][7:0]   mag;
    logic [2:0]        negv;
    logic [2:0][11:0]  s3_msq_next;
    logic [15:0]       s3_s_next;

    logic               s4_vld_reg;
    csm_pkg::csm_item_t s4_itm_reg, s4_itm_next;
    logic [14:0]        ra, ca, re, ce, cs, rf, cf;

    always_comb
    begin
        n_eff = grid;
        if (grid < csm_pkg::GRID_MIN)
        begin
            n_eff = csm_pkg::GRID_MIN;
        end
        else if (grid > csm_pkg::GRID_MAX)
        begin
            n_eff = csm_pkg::GRID_MAX;
        end
        keep = (req.face <= csm_pkg::FACE_NZ) && ({1'b0, req.row} < n_eff)
            && ({1'b0, req.col} < n_eff);
        if (req.req_type == csm_pkg::REQ_SEGMENT && {1'b0, req.row} >= n_eff - 7'd1)
        begin
            keep = 1'b0;
        end
        s1_vld_next = req_valid && keep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_comb
    begin
        s2_d_next = 8'(signed'({1'b0, s1_n_reg}) - 8'sd1);
        s2_a_next = 8'(signed'({1'b0, s1_i_reg, 1'b0}) - s2_d_next);
        s2_b_next = 8'(signed'({1'b0, s1_j_reg, 1'b0}) - s2_d_next);
    end

    always_comb
    begin
        unique case (s2_f_reg)
            csm_pkg::FACE_PX:
            begin
                v0 = s2_d_reg;  v1 = s2_b_reg;  v2 = -s2_a_reg;
            end
            csm_pkg::FACE_NX:
            begin
                v0 = -s2_d_reg; v1 = s2_b_reg;  v2 = s2_a_reg;
            end
            csm_pkg::FACE_PY:
            begin
                v0 = s2_a_reg;  v1 = s2_d_reg;  v2 = -s2_b_reg;
            end
            csm_pkg::FACE_NY:
            begin
                v0 = s2_a_reg;  v1 = -s2_d_reg; v2 = s2_b_reg;
            end
            csm_pkg::FACE_PZ:
            begin
                v0 = s2_a_reg;  v1 = s2_b_reg;  v2 = s2_d_reg;
            end
            default:
            begin
                v0 = -s2_a_reg; v1 = s2_b_reg;  v2 = -s2_d_reg;
            end
        endcase
        negv = {v2[7], v1[7], v0[7]};
        mag[0] = v0[7] ? 8'(-v0) : 8'(v0);
        mag[1] = v1[7] ? 8'(-v1) : 8'(v1);
        mag[2] = v2[7] ? 8'(-v2) : 8'(v2);
        for (int c = 0; c < 3; c++)
        begin
            s3_msq_next[c] = 12'(mag[c][6:0] * mag[c][6:0]);
        end
        s3_s_next = 16'(s2_a_reg * s2_a_reg) + 16'(s2_b_reg * s2_b_reg)
            + 16'(s2_d_reg * s2_d_reg);
    end

    always_comb
    begin
        ra = 15'(s3_lc_reg ? s3_rl_reg : s3_ri_reg);
        ca = 15'(s3_lc_reg ? s3_i_reg : s3_j_reg);
        re = 15'(s3_lc_reg ? s3_rl_reg : s3_rn_reg);
        ce = s3_lc_reg ? 15'(s3_i_reg) + 15'd1 : 15'(s3_j_reg);
        cs = s3_lc_reg ? 15'(s3_n_reg) - 15'd1 : 15'(s3_j_reg);
        rf = 15'(s3_lc_reg ? s3_rn_reg : s3_ri_reg);
        cf = s3_lc_reg ? 15'(s3_n_reg) - 15'd1 : 15'(s3_j_reg) + 15'd1;
        s4_itm_next.seg = s3_seg_reg;
        s4_itm_next.neg = s3_neg_reg;
        for (int c = 0; c < 3; c++)
        begin
            s4_itm_next.tgt[c] = {s3_msq_reg[c], 32'd0};
        end
        s4_itm_next.s = s3_s_reg;
        s4_itm_next.vidx = 15'(s3_ri_reg) + 15'(s3_j_reg) + s3_fb_reg;
        s4_itm_next.s0 = ra + ca + s3_fb_reg;
        s4_itm_next.e0 = re + ce + s3_fb_reg;
        s4_itm_next.s1 = 15'(s3_ri_reg) + cs + s3_fb_reg;
        s4_itm_next.e1 = rf + cf + s3_fb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_seg_reg <= req.req_type;
            s1_f_reg <= req.face;
            s1_i_reg <= req.row;
            s1_j_reg <= req.col;
            s1_n_reg <= n_eff;

            s2_seg_reg <= s1_seg_reg;
            s2_lc_reg <= ({1'b0, s1_j_reg} == s1_n_reg - 7'd1);
            s2_f_reg <= s1_f_reg;
            s2_i_reg <= s1_i_reg;
            s2_j_reg <= s1_j_reg;
            s2_n_reg <= s1_n_reg;
            s2_d_reg <= s2_d_next;
            s2_a_reg <= s2_a_next;
            s2_b_reg <= s2_b_next;
            s2_ri_reg <= 13'(s1_i_reg * s1_n_reg);
            s2_rn_reg <= 13'((7'(s1_i_reg) + 7'd1) * s1_n_reg);
            s2_rl_reg <= 13'((s1_n_reg - 7'd1) * s1_n_reg);
            s2_nn_reg <= 13'(s1_n_reg * s1_n_reg);

            s3_seg_reg <= s2_seg_reg;
            s3_lc_reg <= s2_lc_reg;
            s3_i_reg <= s2_i_reg;
            s3_j_reg <= s2_j_reg;
            s3_n_reg <= s2_n_reg;
            s3_ri_reg <= s2_ri_reg;
            s3_rn_reg <= s2_rn_reg;
            s3_rl_reg <= s2_rl_reg;
            s3_neg_reg <= negv;
            s3_msq_reg <= s3_msq_next;
            s3_s_reg <= s3_s_next[13:0];
            s3_fb_reg <= 15'(s2_nn_reg * s2_f_reg);

            s4_itm_reg <= s4_itm_next;
        end
    end

    assign vld = s4_vld_reg;
    assign itm = s4_itm_reg;

endmodule

@@ src/csm_norm.sv @@
// ----------------------------------------------------------------------------
// Cube sphere mesh normalizer
// Finds each scaled unit component one bit per stage with shift-add updates.
// ----------------------------------------------------------------------------
module csm_norm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  csm_pkg::csm_item_t in_itm,
    output logic               vld,
    output csm_pkg::csm_item_t itm,
    output csm_pkg::csm_srch_t srch
);

    logic               vld_reg [csm_pkg::NSTG];
    csm_pkg::csm_item_t itm_reg [csm_pkg::NSTG];
    csm_pkg::csm_srch_t srch_reg [csm_pkg::NSTG];

    for (genvar g = 0; g < csm_pkg::NSTG; g++)
    begin : g_stage
        localparam int BIT = csm_pkg::NSTG - 1 - g;
        logic               src_vld;
        csm_pkg::csm_item_t src_itm;
        csm_pkg::csm_srch_t src_srch, srch_next;
        logic [47:0]        cand;

        if (g == 0)
        begin : g_first
            assign src_vld = in_vld;
            assign src_itm = in_itm;
            assign src_srch = '0;
        end
        else
        begin : g_rest
            assign src_vld = vld_reg[g-1];
            assign src_itm = itm_reg[g-1];
            assign src_srch = srch_reg[g-1];
        end

        always_comb
        begin
            srch_next = src_srch;
            for (int c = 0; c < 3; c++)
            begin
                cand = src_srch.p[c] + ({16'd0, src_srch.q[c]} << (BIT + 1))
                    + ({34'd0, src_itm.s} << (2 * BIT));
                if (cand <= {4'd0, src_itm.tgt[c]})
                begin
                    srch_next.p[c] = cand;
                    srch_next.q[c] = src_srch.q[c] + ({18'd0, src_itm.s} << BIT);
                    srch_next.u[c] = src_srch.u[c] | (16'd1 << BIT);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[g] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                itm_reg[g] <= src_itm;
                srch_reg[g] <= srch_next;
            end
        end
    end

    assign vld = vld_reg[csm_pkg::NSTG-1];
    assign itm = itm_reg[csm_pkg::NSTG-1];
    assign srch = srch_reg[csm_pkg::NSTG-1];

endmodule

@@ src/csm_out.sv @@
// ----------------------------------------------------------------------------
// Cube sphere mesh output stage
// Rounds and clamps the directions and sends one or two result words.
// ----------------------------------------------------------------------------
module csm_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vld,
    input  csm_pkg::csm_item_t itm,
    input  csm_pkg::csm_srch_t srch,
    input  logic               res_ready,
    output logic               res_valid,
    output csm_pkg::csm_res_t  res,
    output logic               en
);

    logic second_reg, second_next;
    logic [2:0][15:0] dir;
    logic [16:0]      lo;
    logic [15:0]      mag;
    logic             fire;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            lo = ({1'b0, srch.u[c]} + 17'd1) >> 1;
            mag = (lo > 17'd32767) ? 16'd32767 : lo[15:0];
            dir[c] = itm.neg[c] ? 16'(-mag) : mag;
        end
    end

    always_comb
    begin
        res = '0;
        if (itm.seg == csm_pkg::REQ_SEGMENT)
        begin
            res.seg_start = second_reg ? itm.s1 : itm.s0;
            res.seg_end = second_reg ? itm.e1 : itm.e0;
            res.last = second_reg;
        end
        else
        begin
            res.vertex_index = itm.vidx;
            res.dir_x = dir[0];
            res.dir_y = dir[1];
            res.dir_z = dir[2];
            res.last = 1'b1;
        end
        res_valid = vld;
        fire = vld && res_ready;
        en = !vld || (fire && res.last);
        second_next = second_reg;
        if (fire)
        begin
            second_next = !res.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg <= 1'b0;
        end
        else
        begin
            second_reg <= second_next;
        end
    end

endmodule

@@ src/cube_sphere_mesh_generator.sv @@
// An accepted request passes the front-end registers and the normalizer stages.
// Throughput: one vertex request per cycle while res_ready is high; a segment
// request stalls the pipeline while its two words leave the output one per cycle.
// The depth is set by the 16-stage bit-serial normalizer, one result bit a stage.
// Reset clears all valid bits and sets grid_reg to 10; no memory is cleared.
// ----------------------------------------------------------------------------
// Cube sphere mesh generator
// Top level: configuration register, front end, normalizer and output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cube_sphere_mesh_generator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [6:0]        cfg_wdata,
    input  logic              req_valid,
    output logic              req_ready,
    input  csm_pkg::csm_req_t req,
    output logic              res_valid,
    input  logic              res_ready,
    output csm_pkg::csm_res_t res
);

    logic [6:0]         grid_reg;
    logic               en;
    logic               f_vld, n_vld;
    csm_pkg::csm_item_t f_itm, n_itm;
    csm_pkg::csm_srch_t n_srch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg <= csm_pkg::GRID_RESET;
        end
        else if (cfg_we)
        begin
            grid_reg <= cfg_wdata;
        end
    end

    assign req_ready = en;

    csm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .grid      (grid_reg),
        .req_valid (req_valid),
        .req       (req),
        .vld       (f_vld),
        .itm       (f_itm)
    );

    csm_norm u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_vld (f_vld),
        .in_itm (f_itm),
        .vld    (n_vld),
        .itm    (n_itm),
        .srch   (n_srch)
    );

    csm_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .vld       (n_vld),
        .itm       (n_itm),
        .srch      (n_srch),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res),
        .en        (en)
    );

    `CSM_ASSERT(a_seg_pair, clk, rst_n, res_valid && res_ready && !res.last |=> res_valid && res.last)
    `CSM_ASSERT(a_first_seg, clk, rst_n, res_valid && !res.last |-> res.vertex_index == 15'd0 && res.dir_x == 16'sd0)
    `CSM_NEVER(a_no_min, clk, rst_n, res_valid && (res.dir_x == 16'sh8000 || res.dir_y == 16'sh8000 || res.dir_z == 16'sh8000))

endmodule

@@ tb/sv/cube_sphere_mesh_generator_tb.sv @@
// ----------------------------------------------------------------------------
// Cube sphere mesh generator testbench
// Sends vertex and segment requests over several grid sizes, with random gaps
// on both sides and one long output stall. Each result word is compared with
// a local model of the face mapping, the Q1.15 normalization and the segment
// index pairs, or with fixed values for the directed segment requests.
// ----------------------------------------------------------------------------
module cube_sphere_mesh_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 170;

    typedef struct {
        csm_pkg::csm_req_t r;
        bit                typed;
        int                nres;
        csm_pkg::csm_res_t e0;
        csm_pkg::csm_res_t e1;
    } stim_row_t;

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    logic [6:0] cfg_wdata;
    logic     req_valid;
    logic     req_ready;
    csm_pkg::csm_req_t req;
    logic     res_valid;
    logic     res_ready;
    csm_pkg::csm_res_t res;

    csm_pkg::csm_res_t expected_words[$];
    stim_row_t directed[$];
    logic [6:0] grid_reg;
    int errors;
    int words_seen;
    int items_sent;
    int idle_cycles;
    int vertex_words;
    int segment_words;

    cube_sphere_mesh_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic void queue_word(csm_pkg::csm_res_t w);
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic int grid_points();
        int n;
        n = grid_reg;
        if (n < 2)
            n = 2;
        if (n > csm_pkg::MAX_GRID)
            n = csm_pkg::MAX_GRID;
        return n;
    endfunction

    function automatic logic [15:0] unit_q15(longint c, longint unsigned s);
        longint unsigned m, target, lo, hi, mid, t;
        m = (c < 0) ? -c : c;
        target = (m * m) << 32;
        lo = 0;
        hi = 32768;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            t = 2 * mid - 1;
            if (t * t * s <= target)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (lo > 32767)
            lo = 32767;
        if (c < 0)
            return 16'(17'h10000 - lo);
        return 16'(lo);
    endfunction

    function automatic logic [14:0] grid_index(int i, int j, int f, int n);
        return 15'(i * n + j + n * n * f);
    endfunction

    function automatic csm_pkg::csm_res_t segment_word(int s, int e, bit last);
        csm_pkg::csm_res_t w;
        w = '0;
        w.seg_start = 15'(s);
        w.seg_end = 15'(e);
        w.last = last;
        return w;
    endfunction

    function automatic void predict_mesh(csm_pkg::csm_req_t r);
        int n, i, j, f;
        longint d, a, b, s;
        longint v[3];
        csm_pkg::csm_res_t w;
        n = grid_points();
        i = r.row;
        j = r.col;
        f = r.face;
        if (f > 5 || i >= n || j >= n)
            return;
        if (r.req_type == csm_pkg::REQ_VERTEX)
        begin
            d = n - 1;
            a = 2 * i - d;
            b = 2 * j - d;
            s = a * a + b * b + d * d;
            case (r.face)
                csm_pkg::FACE_PX: v = '{d, b, -a};
                csm_pkg::FACE_NX: v = '{-d, b, a};
                csm_pkg::FACE_PY: v = '{a, d, -b};
                csm_pkg::FACE_NY: v = '{a, -d, b};
                csm_pkg::FACE_PZ: v = '{a, b, d};
                default: v = '{-a, b, -d};
            endcase
            w = '0;
            w.vertex_index = grid_index(i, j, f, n);
            w.dir_x = unit_q15(v[0], s);
            w.dir_y = unit_q15(v[1], s);
            w.dir_z = unit_q15(v[2], s);
            w.last = 1'b1;
            queue_word(w);
            return;
        end
        if (i >= n - 1)
            return;
        if (j < n - 1)
        begin
            queue_word(segment_word(grid_index(i, j, f, n),
                grid_index(i + 1, j, f, n), 1'b0));
            queue_word(segment_word(grid_index(i, j, f, n),
                grid_index(i, j + 1, f, n), 1'b1));
        end
        else
        begin
            queue_word(segment_word(grid_index(n - 1, i, f, n),
                grid_index(n - 1, i + 1, f, n), 1'b0));
            queue_word(segment_word(grid_index(i, n - 1, f, n),
                grid_index(i + 1, n - 1, f, n), 1'b1));
        end
    endfunction

    function automatic csm_pkg::csm_req_t make_req(logic t, int f, int i, int j);
        csm_pkg::csm_req_t r;
        r.req_type = t;
        r.face = 3'(f);
        r.row = 6'(i);
        r.col = 6'(j);
        return r;
    endfunction

    function automatic void add_row(csm_pkg::csm_req_t r, bit typed, int nres,
                                    csm_pkg::csm_res_t e0, csm_pkg::csm_res_t e1);
        stim_row_t row;
        row.r = r;
        row.typed = typed;
        row.nres = nres;
        row.e0 = e0;
        row.e1 = e1;
        directed.insert(directed.size(), row);
    endfunction

    task automatic report(string what, csm_pkg::csm_res_t got, csm_pkg::csm_res_t want);
        errors++;
        $display("mismatch at word %0d: %s got %h expected %h", words_seen, what, got, want);
    endtask

    task automatic send_item(csm_pkg::csm_req_t r, bit typed, int nres,
                             csm_pkg::csm_res_t e0, csm_pkg::csm_res_t e1);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
        items_sent++;
        if (typed)
        begin
            if (nres > 0)
                queue_word(e0);
            if (nres > 1)
                queue_word(e1);
        end
        else
            predict_mesh(r);
    endtask

    task automatic write_grid(logic [6:0] value);
        req_valid <= 1'b0;
        wait (expected_words.size() == 0);
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        grid_reg = value;
    endtask

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int wait_n;
        bit held;
        csm_pkg::csm_res_t want;
        held = 1'b0;
        res_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && words_seen == 150)
            begin
                held = 1'b1;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (wait_n > 0)
            begin
                res_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            res_ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_valid);
            if (expected_words.size() == 0)
                report("unexpected word", res, '0);
            else
            begin
                want = expected_words.pop_front();
                if (want.seg_start != 0 || want.seg_end != 0)
                    segment_words++;
                else
                    vertex_words++;
                if (res.vertex_index !== want.vertex_index)
                    report("vertex_index", res, want);
                if (res.dir_x !== want.dir_x)
                    report("dir_x", res, want);
                if (res.dir_y !== want.dir_y)
                    report("dir_y", res, want);
                if (res.dir_z !== want.dir_z)
                    report("dir_z", res, want);
                if (res.seg_start !== want.seg_start)
                    report("seg_start", res, want);
                if (res.seg_end !== want.seg_end)
                    report("seg_end", res, want);
                if (res.last !== want.last)
                    report("last", res, want);
            end
            words_seen++;
        end
    end

    initial
    begin
        logic [6:0] grids[6];
        csm_pkg::csm_res_t none;
        int n, f;
        errors = 0;
        words_seen = 0;
        items_sent = 0;
        idle_cycles = 0;
        vertex_words = 0;
        segment_words = 0;
        none = '0;
        grid_reg = csm_pkg::GRID_RESET;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_valid = 1'b0;
        req = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (f = 0; f < 6; f++)
            add_row(make_req(csm_pkg::REQ_VERTEX, f, 0, 0), 0, 0, none, none);
        add_row(make_req(csm_pkg::REQ_VERTEX, csm_pkg::FACE_NZ, 9, 9), 0, 0, none, none);
        add_row(make_req(csm_pkg::REQ_VERTEX, csm_pkg::FACE_PY, 4, 5), 0, 0, none, none);
        add_row(make_req(csm_pkg::REQ_SEGMENT, csm_pkg::FACE_PX, 0, 0), 1, 2,
                segment_word(0, 10, 0), segment_word(0, 1, 1));
        add_row(make_req(csm_pkg::REQ_SEGMENT, csm_pkg::FACE_PX, 3, 9), 1, 2,
                segment_word(93, 94, 0), segment_word(39, 49, 1));
        add_row(make_req(csm_pkg::REQ_SEGMENT, csm_pkg::FACE_NZ, 0, 0), 1, 2,
                segment_word(500, 510, 0), segment_word(500, 501, 1));
        add_row(make_req(csm_pkg::REQ_SEGMENT, csm_pkg::FACE_PZ, 8, 8), 0, 0, none, none);
        add_row(make_req(csm_pkg::REQ_SEGMENT, csm_pkg::FACE_PX, 9, 2), 1, 0, none, none);
        add_row(make_req(csm_pkg::REQ_VERTEX, 6, 0, 0), 1, 0, none, none);
        add_row(make_req(csm_pkg::REQ_SEGMENT, 7, 1, 1), 1, 0, none, none);
        add_row(make_req(csm_pkg::REQ_VERTEX, csm_pkg::FACE_PX, 10, 0), 1, 0, none, none);
        add_row(make_req(csm_pkg::REQ_VERTEX, csm_pkg::FACE_NY, 0, 63), 1, 0, none, none);
        add_row(make_req(csm_pkg::REQ_SEGMENT, csm_pkg::FACE_NX, 63, 63), 1, 0, none, none);
        foreach (directed[k])
            send_item(directed[k].r, directed[k].typed, directed[k].nres,
                      directed[k].e0, directed[k].e1);

        grids = '{7'd64, 7'd2, 7'd127, 7'd0, 7'd37, 7'd1};
        foreach (grids[g])
        begin
            write_grid(grids[g]);
            n = grid_points();
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(make_req($urandom_range(0, 1), $urandom_range(0, 7),
                              $urandom_range(0, 63), $urandom_range(0, 63)),
                              0, 0, none, none);
                else
                    send_item(make_req($urandom_range(0, 1), $urandom_range(0, 5),
                              $urandom_range(0, n - 1), $urandom_range(0, n - 1)),
                              0, 0, none, none);
            end
        end
        req_valid <= 1'b0;

        wait (expected_words.size() == 0);
        repeat (SETTLE) @(posedge clk);
        $display("covered %0d requests over 7 grid settings, including a long output stall",
                 items_sent);
        $display("checked %0d vertex words and %0d segment words, %0d errors",
                 vertex_words, segment_words, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+src
src/csm_pkg.sv
src/csm_front.sv
src/csm_norm.sv
src/csm_out.sv
src/cube_sphere_mesh_generator.sv
tb/sv/cube_sphere_mesh_generator_tb.sv
